### rtl/isort_pkg.sv
// Shared types and constants for the insertion sort engine.
// No dependencies; imported by every module of the block.
package isort_pkg;

    // One input item as it travels from the front stage through the queue
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_item;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

### rtl/isort_front.sv
// Front stage of the insertion sort engine: input register and push into the queue.
// Depends on isort_pkg (t_item).
module isort_front import isort_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_value,
    input  logic               i_last_in,
    input  logic               i_full,
    output logic               o_push,
    output t_item              o_item
);

    logic  r_vld;
    t_item r_item;

    // Push the held item whenever the queue has room
    assign o_push  = r_vld && !i_full;
    assign o_ready = !r_vld || !i_full;
    assign o_item  = r_item;

    // Hold one item; refill in the cycle it leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    // Capture the incoming item and its last flag
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.value <= i_value;
            r_item.last  <= i_last_in;
        end
    end

endmodule

### rtl/isort_queue.sv
// Short FIFO of items between the front and back parts of the sort engine.
// Depends on isort_pkg (t_item, QUEUE_DEPTH, QPTR_W).
module isort_queue import isort_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item            r_mem [QUEUE_DEPTH];
    logic [QPTR_W:0]  r_wr_ptr;
    logic [QPTR_W:0]  r_rd_ptr;

    // Compare wrap bits to tell full from empty
    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[QPTR_W] != r_rd_ptr[QPTR_W]) &&
                     (r_wr_ptr[QPTR_W-1:0] == r_rd_ptr[QPTR_W-1:0]);
    assign o_item  = r_mem[r_rd_ptr[QPTR_W-1:0]];

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[QPTR_W-1:0]] <= i_item;
        end
    end

endmodule

### rtl/isort_back.sv
// Back part of the sort engine: row of compare-and-shift cells, drain sequencer
// and output register. Depends on isort_pkg (t_item).
module isort_back import isort_pkg::*; #(
    parameter int MAX_ITEMS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sorted_value,
    output logic               o_last_out,
    output logic               o_dropped
);

    localparam int   FILL_W  = $clog2(MAX_ITEMS + 1);
    localparam logic ST_INS  = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                r_state;
    logic [FILL_W-1:0]   r_fill;
    logic                r_ovf;
    logic signed [31:0]  r_cell [MAX_ITEMS];
    logic signed [31:0]  n_cell [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] w_gt;
    logic                w_full;
    logic                w_ins;
    logic                w_ld;
    logic                r_ovld;
    logic signed [31:0]  r_oval;
    logic                r_olast;
    logic                r_odrop;

    assign w_full = (r_fill == FILL_W'(MAX_ITEMS));
    assign o_pop  = (r_state == ST_INS) && !i_empty;
    assign w_ins  = o_pop && !w_full;
    assign w_ld   = (r_state == ST_EMIT) && (!r_ovld || i_ready);

    assign o_valid        = r_ovld;
    assign o_sorted_value = r_oval;
    assign o_last_out     = r_olast;
    assign o_dropped      = r_odrop;

    // Mark cells that sit after the new value; empty cells count as after
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            w_gt[i] = (FILL_W'(i) < r_fill) ? (i_item.value < r_cell[i]) : 1'b1;
        end
    end

    // Insert by shifting up, or drain by shifting down toward cell zero
    always_comb begin
        if (w_ld) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
            n_cell[MAX_ITEMS-1] = r_cell[MAX_ITEMS-1];
        end else begin
            n_cell[0] = w_gt[0] ? i_item.value : r_cell[0];
            for (int i = 1; i < MAX_ITEMS; i++) begin
                if (!w_gt[i]) begin
                    n_cell[i] = r_cell[i];
                end else if (!w_gt[i-1]) begin
                    n_cell[i] = i_item.value;
                end else begin
                    n_cell[i] = r_cell[i-1];
                end
            end
        end
    end

    // Update cells
    always_ff @(posedge i_clk) begin
        if (w_ins || w_ld) begin
            r_cell <= n_cell;
        end
    end

    // Sequence insertion and drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INS;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_INS: begin
                    if (o_pop) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                        if (i_item.last) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_ld) begin
                        r_fill <= r_fill - 1'b1;
                        if (r_fill == FILL_W'(1)) begin
                            r_state <= ST_INS;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: r_state <= ST_INS;
            endcase
        end
    end

    // Fill the output register on a load, empty it when the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_ld) begin
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    // Load the output register from the lowest cell
    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_oval  <= r_cell[0];
            r_olast <= (r_fill == FILL_W'(1));
            r_odrop <= r_ovf;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_fill != '0))
        else $error("drain with empty store");

    a_batch_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld && r_fill == FILL_W'(1)) |=> (r_state == ST_INS && r_fill == '0 && !r_ovf))
        else $error("batch not cleared after final result");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld |=> (o_last_out == (r_state == ST_INS)))
        else $error("final flag does not match end of drain");

endmodule

### rtl/insertion_sort_engine.sv
// Top level of the insertion sort engine: front stage, item queue and cell row.
// Depends on isort_pkg, isort_front, isort_queue and isort_back.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-----------------------------------------
//  input   | i_valid | o_ready | i_value, i_last_in
//  output  | o_valid | i_ready | o_sorted_value, o_last_out, o_dropped
//
// Each value is inserted by the compare-and-shift cell row; an accepted value
// passes through the front register and the queue before it reaches the row.
// After the last item of a batch, the row drains one result a cycle while the output is ready,
// N results in all (N = stored values, at most MAX_ITEMS); no new item is inserted meanwhile.
// Reset clears pointers, fill count and flags; the cell contents need no clearing.
// Input stalls only when the four-entry queue and front register are full;
// an output stall holds the drain.
module insertion_sort_engine import isort_pkg::*; #(
    parameter int MAX_ITEMS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_value,
    input  logic               i_last_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sorted_value,
    output logic               o_last_out,
    output logic               o_dropped
);

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_item w_front_item;
    t_item w_queue_item;

    isort_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_value   (i_value),
        .i_last_in (i_last_in),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    isort_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    isort_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_item         (w_queue_item),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_dropped      (o_dropped)
    );

endmodule
